// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the debounced button counter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define DBC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds on a rising clock edge outside reset.
`define DBC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DBC_ASSERT(label, clk, rst_n, prop, msg)
`define DBC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/dbc_pkg.sv =====
// Shared constants, types and the segment table of the debounced button counter.
package dbc_pkg;

	localparam int NUM_BUTTONS = 8;
	localparam int COUNT_LIMIT = 1023;

	localparam int HIST_W = 13;
	localparam logic [HIST_W-1:0] HIST_PRESS = 13'h1000;

	localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
	localparam int SUM_W = $clog2(COUNT_LIMIT + (2 ** NUM_BUTTONS));
	localparam int OUT_CNT_W = 10;

	localparam int SEG_W = 8;
	localparam int DIG_W = 4;
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

	// reciprocal multipliers for the decimal split, exact for counts up to 9999
	localparam int DEC_BASE = 10;
	localparam int DIV10_MUL = 52429;
	localparam int DIV10_SH = 19;
	localparam int DIV100_MUL = 5243;
	localparam int DIV100_SH = 19;
	localparam int DIV1000_MUL = 16778;
	localparam int DIV1000_SH = 24;
	localparam int PROD_W = CNT_W + 25;

	typedef struct packed {
		logic [SEG_W-1:0] thousands;
		logic [SEG_W-1:0] hundreds;
		logic [SEG_W-1:0] colon;
		logic [SEG_W-1:0] tens;
		logic [SEG_W-1:0] ones;
	} digit_segs_t;

	// active-low segment pattern of one decimal digit
	function automatic logic [SEG_W-1:0] seg_code(input logic [DIG_W-1:0] d);
		logic [SEG_W-1:0] code;
		case (d)
			4'd0: code = 8'b11000000;
			4'd1: code = 8'b11111001;
			4'd2: code = 8'b10100100;
			4'd3: code = 8'b10110000;
			4'd4: code = 8'b10011001;
			4'd5: code = 8'b10010010;
			4'd6: code = 8'b10000010;
			4'd7: code = 8'b11111000;
			4'd8: code = 8'b10000000;
			4'd9: code = 8'b10010000;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/core/dbc_debounce.sv =====
// Per-button sample history and single-shot press detection.
module dbc_debounce (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic [dbc_pkg::NUM_BUTTONS-1:0]  levels,
	output logic [dbc_pkg::NUM_BUTTONS-1:0]  press
);

	logic [dbc_pkg::HIST_W-1:0] hist_q [dbc_pkg::NUM_BUTTONS];
	logic [dbc_pkg::HIST_W-1:0] hist_d [dbc_pkg::NUM_BUTTONS];

	always_comb begin
		for (int i = 0; i < dbc_pkg::NUM_BUTTONS; i++) begin
			hist_d[i] = {hist_q[i][dbc_pkg::HIST_W-2:0], levels[i]};
			// one high sample followed by twelve low ones
			press[i]  = (hist_d[i] == dbc_pkg::HIST_PRESS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dbc_pkg::NUM_BUTTONS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < dbc_pkg::NUM_BUTTONS; i++) begin
				hist_q[i] <= hist_d[i];
			end
		end
	end

endmodule

// ===== rtl/core/dbc_counter.sv =====
// Running count: add the weighted presses and fall back to one once past the limit.
module dbc_counter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic [dbc_pkg::NUM_BUTTONS-1:0]  press,
	output logic [dbc_pkg::CNT_W-1:0]        count_q
);

	logic [dbc_pkg::SUM_W-1:0] sum;
	logic [dbc_pkg::CNT_W-1:0] count_d;

	// button i weighs 2^i, so the press vector is already the increment
	always_comb begin
		sum = dbc_pkg::SUM_W'(count_q) + dbc_pkg::SUM_W'(press);
		if (sum > dbc_pkg::SUM_W'(dbc_pkg::COUNT_LIMIT)) begin
			count_d = dbc_pkg::CNT_W'(1);
		end else begin
			count_d = sum[dbc_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= dbc_pkg::CNT_W'(dbc_pkg::COUNT_LIMIT);
		end else if (advance) begin
			count_q <= count_d;
		end
	end

endmodule

// ===== rtl/core/dbc_seg7.sv =====
// Decimal split of the count and seven-segment encoding with leading-zero blanking.
module dbc_seg7 (
	input  logic [dbc_pkg::CNT_W-1:0] count,
	output dbc_pkg::digit_segs_t      segs
);

	logic [dbc_pkg::PROD_W-1:0] p10, p100, p1000;
	logic [dbc_pkg::CNT_W-1:0]  q10, q100, q1000;
	logic [dbc_pkg::DIG_W-1:0]  d0, d1, d2, d3;
	logic                       blank3, blank2, blank1;

	always_comb begin
		p10   = dbc_pkg::PROD_W'(count) * dbc_pkg::PROD_W'(dbc_pkg::DIV10_MUL);
		p100  = dbc_pkg::PROD_W'(count) * dbc_pkg::PROD_W'(dbc_pkg::DIV100_MUL);
		p1000 = dbc_pkg::PROD_W'(count) * dbc_pkg::PROD_W'(dbc_pkg::DIV1000_MUL);
		q10   = p10[dbc_pkg::DIV10_SH +: dbc_pkg::CNT_W];
		q100  = p100[dbc_pkg::DIV100_SH +: dbc_pkg::CNT_W];
		q1000 = p1000[dbc_pkg::DIV1000_SH +: dbc_pkg::CNT_W];

		d0 = dbc_pkg::DIG_W'(count - dbc_pkg::CNT_W'(q10 * dbc_pkg::CNT_W'(dbc_pkg::DEC_BASE)));
		d1 = dbc_pkg::DIG_W'(q10 - dbc_pkg::CNT_W'(q100 * dbc_pkg::CNT_W'(dbc_pkg::DEC_BASE)));
		d2 = dbc_pkg::DIG_W'(q100 - dbc_pkg::CNT_W'(q1000 * dbc_pkg::CNT_W'(dbc_pkg::DEC_BASE)));
		d3 = dbc_pkg::DIG_W'(q1000);

		blank3 = (d3 == '0);
		blank2 = blank3 && (d2 == '0);
		blank1 = blank2 && (d1 == '0);

		segs.thousands = blank3 ? dbc_pkg::SEG_BLANK : dbc_pkg::seg_code(d3);
		segs.hundreds  = blank2 ? dbc_pkg::SEG_BLANK : dbc_pkg::seg_code(d2);
		segs.tens      = blank1 ? dbc_pkg::SEG_BLANK : dbc_pkg::seg_code(d1);
		segs.colon     = dbc_pkg::SEG_BLANK;
		segs.ones      = dbc_pkg::seg_code(d0);
	end

endmodule

// ===== rtl/core/debounced_button_counter_7seg.sv =====
// Top level of the debounced button counter with seven-segment digit codes.
//
// Each input beat carries one sampling tick of eight active-low buttons. On
// the accepting edge every button's 13-sample history shifts and the running
// count (reset value 1023) takes the weight 2^i of each button whose history
// now reads one high sample followed by twelve low ones; a sum above 1023
// falls back to 1. The output register, unless stalled, loads the count and its
// four active-low digit codes (leading zeros blank, colon always blank); each
// beat goes through the count and output registers. One beat is taken every
// cycle unless the consumer stalls with both stages full: the count register
// is the only feedback path, and its add and limit compare are combinational.
// The output register lets a new input beat in while a finished result waits.
`include "assert_macros.svh"

module debounced_button_counter_7seg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  buttons_n,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  seg_ones,
	output logic [7:0]  seg_tens,
	output logic [7:0]  seg_colon,
	output logic [7:0]  seg_hundreds,
	output logic [7:0]  seg_thousands,
	output logic [9:0]  count_value
);

	logic                                 accept;
	logic                                 advance_s1;
	logic                                 valid_s1;
	logic                                 valid_s2;
	logic [dbc_pkg::NUM_BUTTONS-1:0]      press;
	logic [dbc_pkg::CNT_W-1:0]            count_q;
	dbc_pkg::digit_segs_t                 segs;
	dbc_pkg::digit_segs_t                 segs_s2;
	logic [dbc_pkg::OUT_CNT_W-1:0]        count_s2;

	// Stage one is the count register itself: a beat is only taken when stage
	// one is empty or moving on, so count_q always belongs to the beat in it.
	assign advance_s1 = !valid_s2 || out_ready;
	assign in_ready   = !valid_s1 || advance_s1;
	assign accept     = in_valid && in_ready;

	dbc_debounce u_debounce (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.levels  (buttons_n[dbc_pkg::NUM_BUTTONS-1:0]),
		.press   (press)
	);

	dbc_counter u_counter (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.press   (press),
		.count_q (count_q)
	);

	dbc_seg7 u_seg7 (
		.count (count_q),
		.segs  (segs)
	);

	// Stage valid flags: fill on accept, drain when the next stage takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Output register: hold while the consumer stalls.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s1) begin
			segs_s2  <= segs;
			count_s2 <= dbc_pkg::OUT_CNT_W'(count_q);
		end
	end

	assign out_valid     = valid_s2;
	assign seg_ones      = segs_s2.ones;
	assign seg_tens      = segs_s2.tens;
	assign seg_colon     = segs_s2.colon;
	assign seg_hundreds  = segs_s2.hundreds;
	assign seg_thousands = segs_s2.thousands;
	assign count_value   = count_s2;

	`DBC_ASSERT_NEVER(a_count_range, clk, arst_n, (count_q == '0) || (count_q > dbc_pkg::CNT_W'(dbc_pkg::COUNT_LIMIT)), "count left its range")
	`DBC_ASSERT(a_no_overwrite, clk, arst_n, (accept && valid_s1) |-> advance_s1, "beat accepted over a stalled stage one")
	`DBC_ASSERT(a_hold_stalled, clk, arst_n, (valid_s2 && !out_ready) |=> (valid_s2 && $stable(count_s2) && $stable(segs_s2)), "stalled result changed")
	`DBC_ASSERT_NEVER(a_ones_shown, clk, arst_n, valid_s2 && (segs_s2.ones == dbc_pkg::SEG_BLANK), "ones digit blanked")
	`DBC_ASSERT_NEVER(a_colon_blank, clk, arst_n, valid_s2 && (segs_s2.colon != dbc_pkg::SEG_BLANK), "colon not blank")

endmodule

// ===== verif/dbc_display_checker.sv =====
// Checker for the debounced button counter: predicts the display of every tick and compares.
`timescale 1ns / 1ps

module dbc_display_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  buttons_n,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  seg_ones,
	input  logic [7:0]  seg_tens,
	input  logic [7:0]  seg_colon,
	input  logic [7:0]  seg_hundreds,
	input  logic [7:0]  seg_thousands,
	input  logic [9:0]  count_value,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [dbc_pkg::SEG_W-1:0] thousands;
		logic [dbc_pkg::SEG_W-1:0] hundreds;
		logic [dbc_pkg::SEG_W-1:0] colon;
		logic [dbc_pkg::SEG_W-1:0] tens;
		logic [dbc_pkg::SEG_W-1:0] ones;
		logic [9:0]                value;
	} display_t;

	logic [dbc_pkg::HIST_W-1:0] press_hist [dbc_pkg::NUM_BUTTONS];
	int unsigned                tally;
	display_t                   display_q [$];
	int                         reported;

	// active-low pattern of one decimal digit
	function automatic logic [dbc_pkg::SEG_W-1:0] digit_pattern(input int unsigned d);
		logic [dbc_pkg::SEG_W-1:0] pat;
		case (d)
			0: pat = 8'hC0;
			1: pat = 8'hF9;
			2: pat = 8'hA4;
			3: pat = 8'hB0;
			4: pat = 8'h99;
			5: pat = 8'h92;
			6: pat = 8'h82;
			7: pat = 8'hF8;
			8: pat = 8'h80;
			default: pat = 8'h90;
		endcase
		return pat;
	endfunction

	// split into four digits, blank leading zeros above the ones digit
	function automatic display_t encode_display(input int unsigned total);
		display_t disp;
		int unsigned d3, d2, d1;
		d3 = (total / 1000) % 10;
		d2 = (total / 100) % 10;
		d1 = (total / 10) % 10;
		disp.thousands = (d3 == 0) ? dbc_pkg::SEG_BLANK : digit_pattern(d3);
		disp.hundreds = (d3 == 0 && d2 == 0) ? dbc_pkg::SEG_BLANK : digit_pattern(d2);
		disp.tens = (d3 == 0 && d2 == 0 && d1 == 0) ? dbc_pkg::SEG_BLANK : digit_pattern(d1);
		disp.colon = dbc_pkg::SEG_BLANK;
		disp.ones = digit_pattern(total % 10);
		disp.value = total[9:0];
		return disp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		display_t want;
		display_t got;
		int unsigned sum;
		logic [dbc_pkg::HIST_W-1:0] h;
		if (!arst_n) begin
			for (int b = 0; b < dbc_pkg::NUM_BUTTONS; b++)
				press_hist[b] = '0;
			tally = dbc_pkg::COUNT_LIMIT;
			display_q.delete();
			fail_count = 0;
			reported = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {seg_thousands, seg_hundreds, seg_colon, seg_tens, seg_ones, count_value};
				if (display_q.size() == 0) begin
					fail_count++;
					if (reported < 10)
						$display("%0t: unexpected result beat, count %0d", $realtime, count_value);
					reported++;
				end else begin
					want = display_q.pop_front();
					if (want !== got) begin
						fail_count++;
						if (reported < 10)
							$display("%0t: mismatch exp th %h hu %h co %h te %h on %h cnt %0d, got th %h hu %h co %h te %h on %h cnt %0d",
								$realtime, want.thousands, want.hundreds, want.colon,
								want.tens, want.ones, want.value, got.thousands,
								got.hundreds, got.colon, got.tens, got.ones, got.value);
						reported++;
					end
				end
			end
			if (in_valid && in_ready) begin
				sum = tally;
				for (int b = 0; b < dbc_pkg::NUM_BUTTONS; b++) begin
					h = {press_hist[b][dbc_pkg::HIST_W-2:0], buttons_n[b]};
					press_hist[b] = h;
					if (h == dbc_pkg::HIST_PRESS)
						sum += (1 << b);
				end
				// overflow of any size falls back to one
				if (sum > dbc_pkg::COUNT_LIMIT)
					sum = 1;
				tally = sum;
				display_q.push_back(encode_display(sum));
			end
		end
		pending = display_q.size();
	end

endmodule

// ===== verif/tb_debounced_button_counter_7seg.sv =====
// Testbench top for the debounced button counter: drives button ticks and gives the verdict.
`timescale 1ns / 1ps

module tb_debounced_button_counter_7seg;

	localparam int RANDOM_PER_PHASE = 483;
	localparam int LONG_HOLD_AT = 1100;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int NOISE_PCT = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  buttons_n = 8'hFF;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  seg_ones;
	logic [7:0]  seg_tens;
	logic [7:0]  seg_colon;
	logic [7:0]  seg_hundreds;
	logic [7:0]  seg_thousands;
	logic [9:0]  count_value;

	int          fail_count;
	int          pending;

	// idle rates in percent, switched per phase by the stimulus process
	int          send_idle_pct = 9;
	int          recv_idle_pct = 63;
	int          beats_sent = 0;

	// receiver long hold-off bookkeeping
	int          hold_left = 0;
	bit          long_hold_done = 1'b0;

	// per-button level runs for well-formed press sequences (1 = released)
	logic [7:0]  run_level = 8'hFF;
	int          run_left [8];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	debounced_button_counter_7seg DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.buttons_n     (buttons_n),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.seg_ones      (seg_ones),
		.seg_tens      (seg_tens),
		.seg_colon     (seg_colon),
		.seg_hundreds  (seg_hundreds),
		.seg_thousands (seg_thousands),
		.count_value   (count_value)
	);

	dbc_display_checker display_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.buttons_n     (buttons_n),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.seg_ones      (seg_ones),
		.seg_tens      (seg_tens),
		.seg_colon     (seg_colon),
		.seg_hundreds  (seg_hundreds),
		.seg_thousands (seg_thousands),
		.count_value   (count_value),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Offer one tick of button levels: idle at random first, then hold valid
	// and the levels steady until the beat is taken.
	task automatic send_tick(input logic [7:0] levels);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		buttons_n <= levels;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	// Build the next tick. Mostly advance each button's level run: short
	// released runs, then low runs that are either bounces (too short to
	// count) or held long enough for a press. Now and then drop in a noise
	// byte that breaks the runs.
	task automatic make_tick(output logic [7:0] levels);
		if ($urandom_range(0, 99) < NOISE_PCT) begin
			levels = 8'($urandom_range(0, 255));
		end else begin
			for (int b = 0; b < 8; b++) begin
				if (run_left[b] == 0) begin
					run_level[b] = ~run_level[b];
					if (run_level[b])
						run_left[b] = $urandom_range(1, 4);
					else if ($urandom_range(0, 3) == 0)
						run_left[b] = $urandom_range(1, 11);
					else
						run_left[b] = $urandom_range(12, 18);
				end
				run_left[b]--;
			end
			levels = run_level;
		end
	endtask

	// Receiver: stall at the phase's rate; once, well into the run, hold off
	// for a long stretch so the block fills and stalls its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!long_hold_done && beats_sent >= LONG_HOLD_AT) begin
			out_ready <= 1'b0;
			hold_left = LONG_HOLD_CYCLES - 1;
			long_hold_done = 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		#400000;
		$display("debounced_button_counter_7seg test failed");
		$finish;
	end

	initial begin
		logic [7:0] levels;
		int waited;
		for (int b = 0; b < 8; b++)
			run_left[b] = 0;

		// hold reset, then release it on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Histories start at zero, so lows straight after
		// reset must not count as a press.
		repeat (3) send_tick(8'h00);
		// one high sample, then twelve lows: every button presses on the
		// same tick, and the sum from 1023 overflows back to one
		send_tick(8'hFF);
		repeat (12) send_tick(8'h00);
		// a following high tick must not count again; then walk single and mixed bits
		send_tick(8'hFF);
		send_tick(8'h80);
		send_tick(8'h01);
		send_tick(8'hAA);
		send_tick(8'h55);

		// Random part: sender sparse idle with a busy receiver, then swapped,
		// then no idling at all (the long receiver hold falls in this phase).
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				make_tick(levels);
				send_tick(levels);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// drain outstanding results, then let the pipeline settle
		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("debounced_button_counter_7seg test passed");
		else
			$display("debounced_button_counter_7seg test failed");
		$finish;
	end

endmodule
